/* design/cpu8ie_pkg.sv */
// ----------------------------------------------------------------------------
// cpu8ie_pkg: shared definitions of the 8-bit CPU execute unit
// Operation codes, status flag positions, reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cpu8ie_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned STACK_AW    = 8;

  // status bit positions: N V 1 B D I Z C
  localparam int unsigned FLAG_N = 7;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0]  SP_RESET     = 8'hFD;
  localparam logic [7:0]  STATUS_RESET = 8'h24;
  localparam logic [15:0] BRK_VECTOR   = 16'hFFFE;

  // operation codes, alphabetical by mnemonic; codes above TYA act as NOP
  typedef enum logic [5:0] {
    OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI,
    OP_BNE, OP_BPL, OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI,
    OP_CLV, OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR,
    OP_INC, OP_INX, OP_INY, OP_JMP, OP_JSR, OP_LDA, OP_LDX, OP_LDY,
    OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_ROL,
    OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA,
    OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
  } op_t;

  typedef enum logic {
    ST_CLEAR,
    ST_EXEC
  } exec_state_t;

endpackage

`default_nettype wire

/* design/cpu8ie_ram.sv */
// ----------------------------------------------------------------------------
// cpu8ie_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8ie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/cpu8_instruction_execute.sv */
// ----------------------------------------------------------------------------
// cpu8_instruction_execute: execute unit of a classic 8-bit CPU
// Runs one decoded instruction per beat against A, X, Y, SP, the status
// flags and an internal 256-byte stack page; returns stores and registers.
// ----------------------------------------------------------------------------
//
//  channel  handshake                 payload
//  -------  ------------------------  ----------------------------------------
//  item     item_valid / item_ready   command, operand_value, target_address,
//                                     pc_in
//  result   result_valid/result_ready result_byte, status_out, next_pc,
//                                     vector_fetch, acc_out, x_out, y_out,
//                                     sp_out
//
//  An item beat is captured in a holding register and executed from there;
//  its result beat is registered from the final step. Steps per item are
//  set by the stack RAM (one stack byte per step, registered read):
//  1 for most operations and PHA/PHP, 2 for JSR/PLA/PLP, 3 for BRK/RTS and
//  4 for RTI. After reset all 256 bytes of the stack page are swept to zero,
//  with item_ready low. A stalled result holds only the final step of the
//  next item; while a result waits the item side takes one more beat, runs
//  its intermediate steps and then holds item_ready low.
//
`default_nettype none

module cpu8_instruction_execute (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [5:0]  command,
  input  wire logic [7:0]  operand_value,
  input  wire logic [15:0] target_address,
  input  wire logic [15:0] pc_in,

  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [7:0]       result_byte,
  output logic [7:0]       status_out,
  output logic [15:0]      next_pc,
  output logic             vector_fetch,
  output logic [7:0]       acc_out,
  output logic [7:0]       x_out,
  output logic [7:0]       y_out,
  output logic [7:0]       sp_out
);

  import cpu8ie_pkg::*;

  // sequencer
  exec_state_t         state, state_next;
  logic [STACK_AW-1:0] clr_cnt;
  logic [1:0]          step;

  // held item
  logic                held_valid;
  logic [5:0]          held_cmd;
  logic [7:0]          held_m;
  logic [15:0]         held_target;
  logic [15:0]         held_pc;

  // architectural state
  logic [7:0]          acc, idx_x, idx_y, sp, status;
  logic [7:0]          tmp;

  // next values from the execute logic
  logic [7:0]          acc_next, x_next, y_next, sp_next, status_next, tmp_next;
  logic [7:0]          res_next;
  logic [15:0]         npc_next;
  logic                vec_next;
  logic                last;

  // stack RAM access of this step
  logic                ex_wr_en, ex_rd_en;
  logic [STACK_AW-1:0] ex_wr_addr, ex_rd_addr;
  logic [7:0]          ex_wr_data;
  logic                ram_we, ram_re;
  logic [STACK_AW-1:0] ram_waddr;
  logic [7:0]          ram_wdata, ram_rdata;

  // datapath helpers
  logic [7:0]          addend, cmp_reg, nz_val;
  logic [8:0]          sum, diff;
  logic                nz_en, take;
  logic [15:0]         branch_pc;
  logic [15:0]         pc_m1;

  logic                res_free, advance, take_item, clearing;

  assign clearing  = (state == ST_CLEAR);
  assign res_free  = !result_valid || result_ready;
  // intermediate steps run freely; the final step waits for the result slot
  assign advance   = (state == ST_EXEC) && held_valid && (!last || res_free);
  assign item_ready = (state == ST_EXEC) && (!held_valid || (advance && last));
  assign take_item = item_valid && item_ready;

  // --------------------------------------------------------------------------
  // State machine: clear sweep, then execute
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == STACK_AW'(STACK_DEPTH - 1)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:  state_next = ST_EXEC;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Execute logic: one step of the held item
  // --------------------------------------------------------------------------
  assign addend    = (held_cmd == OP_SBC) ? ~held_m : held_m;
  assign sum       = {1'b0, acc} + {1'b0, addend} + {8'd0, status[FLAG_C]};
  assign diff      = {1'b0, cmp_reg} - {1'b0, held_m};
  assign branch_pc = held_pc + {{8{held_m[7]}}, held_m};
  assign pc_m1     = held_pc - 16'd1;

  always_comb begin
    case (held_cmd)
      OP_CPX:  cmp_reg = idx_x;
      OP_CPY:  cmp_reg = idx_y;
      default: cmp_reg = acc;
    endcase
  end

  always_comb begin
    case (held_cmd)
      OP_BCC:  take = !status[FLAG_C];
      OP_BCS:  take = status[FLAG_C];
      OP_BEQ:  take = status[FLAG_Z];
      OP_BMI:  take = status[FLAG_N];
      OP_BNE:  take = !status[FLAG_Z];
      OP_BPL:  take = !status[FLAG_N];
      OP_BVC:  take = !status[FLAG_V];
      OP_BVS:  take = status[FLAG_V];
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    acc_next    = acc;
    x_next      = idx_x;
    y_next      = idx_y;
    sp_next     = sp;
    status_next = status;
    tmp_next    = tmp;
    res_next    = 8'd0;
    npc_next    = held_pc;
    vec_next    = 1'b0;
    last        = 1'b1;
    ex_wr_en    = 1'b0;
    ex_wr_addr  = sp;
    ex_wr_data  = 8'd0;
    ex_rd_en    = 1'b0;
    ex_rd_addr  = sp + 8'd1;
    nz_en       = 1'b0;
    nz_val      = 8'd0;

    case (held_cmd)
      OP_ADC, OP_SBC: begin
        status_next[FLAG_C] = sum[8];
        status_next[FLAG_V] = (~(acc[7] ^ addend[7])) & (acc[7] ^ sum[7]);
        acc_next = sum[7:0];
        nz_en = 1'b1; nz_val = sum[7:0];
      end
      OP_AND: begin
        acc_next = acc & held_m;
        nz_en = 1'b1; nz_val = acc & held_m;
      end
      OP_ORA: begin
        acc_next = acc | held_m;
        nz_en = 1'b1; nz_val = acc | held_m;
      end
      OP_EOR: begin
        acc_next = acc ^ held_m;
        nz_en = 1'b1; nz_val = acc ^ held_m;
      end
      OP_ASL: begin
        status_next[FLAG_C] = held_m[7];
        res_next = {held_m[6:0], 1'b0};
        nz_en = 1'b1; nz_val = {held_m[6:0], 1'b0};
      end
      OP_LSR: begin
        status_next[FLAG_C] = held_m[0];
        res_next = {1'b0, held_m[7:1]};
        nz_en = 1'b1; nz_val = {1'b0, held_m[7:1]};
      end
      OP_ROL: begin
        status_next[FLAG_C] = held_m[7];
        res_next = {held_m[6:0], status[FLAG_C]};
        nz_en = 1'b1; nz_val = {held_m[6:0], status[FLAG_C]};
      end
      OP_ROR: begin
        status_next[FLAG_C] = held_m[0];
        res_next = {status[FLAG_C], held_m[7:1]};
        nz_en = 1'b1; nz_val = {status[FLAG_C], held_m[7:1]};
      end
      OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS: begin
        npc_next = take ? branch_pc : held_pc;
      end
      OP_BIT: begin
        status_next[FLAG_N] = held_m[7];
        status_next[FLAG_V] = held_m[6];
        status_next[FLAG_Z] = ((acc & held_m) == 8'd0);
      end
      OP_BRK: begin
        // push PC high, PC low, then status with B set; raise I at the end
        ex_wr_en = 1'b1;
        sp_next  = sp - 8'd1;
        case (step)
          2'd0: begin
            status_next[FLAG_B] = 1'b1;
            ex_wr_data = held_pc[15:8];
            last = 1'b0;
          end
          2'd1: begin
            ex_wr_data = held_pc[7:0];
            last = 1'b0;
          end
          default: begin
            ex_wr_data = status;
            status_next[FLAG_I] = 1'b1;
            vec_next = 1'b1;
            npc_next = BRK_VECTOR;
          end
        endcase
      end
      OP_CLC: status_next[FLAG_C] = 1'b0;
      OP_CLD: status_next[FLAG_D] = 1'b0;
      OP_CLI: status_next[FLAG_I] = 1'b0;
      OP_CLV: status_next[FLAG_V] = 1'b0;
      OP_SEC: status_next[FLAG_C] = 1'b1;
      OP_SED: status_next[FLAG_D] = 1'b1;
      OP_SEI: status_next[FLAG_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        status_next[FLAG_C] = !diff[8];
        nz_en = 1'b1; nz_val = diff[7:0];
      end
      OP_DEC: begin
        res_next = held_m - 8'd1;
        nz_en = 1'b1; nz_val = held_m - 8'd1;
      end
      OP_INC: begin
        res_next = held_m + 8'd1;
        nz_en = 1'b1; nz_val = held_m + 8'd1;
      end
      OP_DEX: begin
        x_next = idx_x - 8'd1;
        nz_en = 1'b1; nz_val = idx_x - 8'd1;
      end
      OP_DEY: begin
        y_next = idx_y - 8'd1;
        nz_en = 1'b1; nz_val = idx_y - 8'd1;
      end
      OP_INX: begin
        x_next = idx_x + 8'd1;
        nz_en = 1'b1; nz_val = idx_x + 8'd1;
      end
      OP_INY: begin
        y_next = idx_y + 8'd1;
        nz_en = 1'b1; nz_val = idx_y + 8'd1;
      end
      OP_JMP: npc_next = held_target;
      OP_JSR: begin
        // push return address minus one, high byte first
        ex_wr_en = 1'b1;
        sp_next  = sp - 8'd1;
        if (step == 2'd0) begin
          ex_wr_data = pc_m1[15:8];
          last = 1'b0;
        end else begin
          ex_wr_data = pc_m1[7:0];
          npc_next = held_target;
        end
      end
      OP_LDA: begin
        acc_next = held_m;
        nz_en = 1'b1; nz_val = held_m;
      end
      OP_LDX: begin
        x_next = held_m;
        nz_en = 1'b1; nz_val = held_m;
      end
      OP_LDY: begin
        y_next = held_m;
        nz_en = 1'b1; nz_val = held_m;
      end
      OP_PHA: begin
        ex_wr_en = 1'b1; ex_wr_data = acc;
        sp_next = sp - 8'd1;
      end
      OP_PHP: begin
        ex_wr_en = 1'b1; ex_wr_data = status;
        sp_next = sp - 8'd1;
      end
      OP_PLA: begin
        if (step == 2'd0) begin
          ex_rd_en = 1'b1; sp_next = sp + 8'd1;
          last = 1'b0;
        end else begin
          acc_next = ram_rdata;
          nz_en = 1'b1; nz_val = ram_rdata;
        end
      end
      OP_PLP: begin
        if (step == 2'd0) begin
          ex_rd_en = 1'b1; sp_next = sp + 8'd1;
          last = 1'b0;
        end else begin
          status_next = ram_rdata;
          status_next[FLAG_U] = 1'b1;
        end
      end
      OP_RTS: begin
        // pull low then high, add one
        case (step)
          2'd0: begin
            ex_rd_en = 1'b1; sp_next = sp + 8'd1;
            last = 1'b0;
          end
          2'd1: begin
            tmp_next = ram_rdata;
            ex_rd_en = 1'b1; sp_next = sp + 8'd1;
            last = 1'b0;
          end
          default: npc_next = {ram_rdata, tmp} + 16'd1;
        endcase
      end
      OP_RTI: begin
        // pull status, then PC low and high
        case (step)
          2'd0: begin
            ex_rd_en = 1'b1; sp_next = sp + 8'd1;
            last = 1'b0;
          end
          2'd1: begin
            status_next = ram_rdata;
            status_next[FLAG_U] = 1'b1;
            ex_rd_en = 1'b1; sp_next = sp + 8'd1;
            last = 1'b0;
          end
          2'd2: begin
            tmp_next = ram_rdata;
            ex_rd_en = 1'b1; sp_next = sp + 8'd1;
            last = 1'b0;
          end
          default: npc_next = {ram_rdata, tmp};
        endcase
      end
      OP_STA: res_next = acc;
      OP_STX: res_next = idx_x;
      OP_STY: res_next = idx_y;
      OP_TAX: begin
        x_next = acc;
        nz_en = 1'b1; nz_val = acc;
      end
      OP_TAY: begin
        y_next = acc;
        nz_en = 1'b1; nz_val = acc;
      end
      OP_TSX: begin
        x_next = sp;
        nz_en = 1'b1; nz_val = sp;
      end
      OP_TXA: begin
        acc_next = idx_x;
        nz_en = 1'b1; nz_val = idx_x;
      end
      OP_TXS: sp_next = idx_x;
      OP_TYA: begin
        acc_next = idx_y;
        nz_en = 1'b1; nz_val = idx_y;
      end
      default: ;  // NOP and unused codes
    endcase

    if (nz_en) begin
      status_next[FLAG_N] = nz_val[7];
      status_next[FLAG_Z] = (nz_val == 8'd0);
    end
  end

  // --------------------------------------------------------------------------
  // Stack page: zero sweep after reset, then one access per step
  // --------------------------------------------------------------------------
  assign ram_we    = clearing || (advance && ex_wr_en);
  assign ram_waddr = clearing ? clr_cnt : ex_wr_addr;
  assign ram_wdata = clearing ? 8'd0 : ex_wr_data;
  assign ram_re    = advance && ex_rd_en;

  cpu8ie_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ex_rd_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Control and architectural registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      step         <= 2'd0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      acc          <= 8'd0;
      idx_x        <= 8'd0;
      idx_y        <= 8'd0;
      sp           <= SP_RESET;
      status       <= STATUS_RESET;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + STACK_AW'(1);
      end

      // commit the step; restart the step count after the final one
      if (advance) begin
        acc    <= acc_next;
        idx_x  <= x_next;
        idx_y  <= y_next;
        sp     <= sp_next;
        status <= status_next;
        step   <= last ? 2'd0 : step + 2'd1;
      end

      if (take_item) begin
        held_valid <= 1'b1;
      end else if (advance && last) begin
        held_valid <= 1'b0;
      end

      if (advance && last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_item) begin
      held_cmd    <= command;
      held_m      <= operand_value;
      held_target <= target_address;
      held_pc     <= pc_in;
    end
    if (advance) begin
      tmp <= tmp_next;
    end
    if (advance && last) begin
      result_byte  <= res_next;
      status_out   <= status_next;
      next_pc      <= npc_next;
      vector_fetch <= vec_next;
      acc_out      <= acc_next;
      x_out        <= x_next;
      y_out        <= y_next;
      sp_out       <= sp_next;
    end
  end

endmodule

`default_nettype wire
